@@ rtl/core/fdes_pkg.sv @@
// ----------------------------------------------------------------------------
// fdes_pkg
// shared constants for the directory entry scanner
// ----------------------------------------------------------------------------
package fdes_pkg;

  localparam int unsigned LongNameParts = 20;
  localparam int unsigned PartChars     = 13;
  localparam int unsigned PartWidth     = PartChars * 8 + 4;
  localparam int unsigned AccBytes      = 21;

  localparam logic [7:0] ChEnd     = 8'h00;
  localparam logic [7:0] ChDeleted = 8'hE5;
  localparam logic [7:0] AttrLfn   = 8'h0F;
  localparam logic [7:0] AttrDir   = 8'h10;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChDot     = 8'h2E;
  localparam logic [7:0] MaskReset = 8'h0E;

  // byte offsets of the thirteen characters of a long-name part
  localparam logic [4:0] LfnOffset [PartChars] = '{
    5'd1, 5'd3, 5'd5, 5'd7, 5'd9, 5'd14, 5'd16, 5'd18, 5'd20, 5'd22, 5'd24, 5'd28, 5'd30
  };

  typedef logic [7:0] byte_t;

endpackage

@@ rtl/core/fdes_ram.sv @@
// ----------------------------------------------------------------------------
// fdes_ram
// generic single-port-write ram with registered read
// ----------------------------------------------------------------------------
module fdes_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ rtl/core/fat_directory_entry_scanner_core.sv @@
// ----------------------------------------------------------------------------
// fat_directory_entry_scanner_core
// parses 32-byte directory entries, gathers long names, emits name chunks
// ----------------------------------------------------------------------------
//  channel   direction  handshake               payload
//  in        sink       in_valid_i / in_stall_o  first_of_directory, entry bytes
//  out       source     out_valid_o / out_stall_i record kind, chunk, metadata
//  cfg       sink       cfg_we_i                 skip attribute mask
//
//  long-name parts, deleted entries and entries after an end mark are handled in idle
//  an ordinary entry is accepted, then the length scan reads each stored part
//  (a short name counts as one part) in S_SRD and S_SPR, then each 8-byte chunk
//  takes a buffer check (S_EFILL) and an output load (S_EOUT), plus an append
//  (S_EAPP) and another buffer check for each part it pulls from the part ram
//  reset clears counters, flags and the mask (to 0x0e); the part ram has no reset
//  input stalls while a name is being scanned or emitted, and while a result
//  waits in the output register with the sink stalling
// ----------------------------------------------------------------------------
module fat_directory_entry_scanner_core
  import fdes_pkg::*;
#(
  parameter int unsigned LONG_NAME_PARTS = LongNameParts,
  localparam int unsigned AddrW = (LONG_NAME_PARTS > 1) ? $clog2(LONG_NAME_PARTS) : 1,
  localparam int unsigned CntW  = $clog2(LONG_NAME_PARTS + 1)
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        first_of_directory_i,
  input  logic [63:0] entry_bytes_0_7_i,
  input  logic [63:0] entry_bytes_8_15_i,
  input  logic [63:0] entry_bytes_16_23_i,
  input  logic [63:0] entry_bytes_24_31_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        record_kind_o,
  output logic [63:0] name_chunk_o,
  output logic [3:0]  chunk_length_o,
  output logic        last_chunk_o,
  output logic        is_directory_o,
  output logic [31:0] file_size_o,
  output logic [15:0] first_cluster_o,
  output logic [15:0] created_date_o,
  output logic [15:0] created_time_o,
  output logic [15:0] modified_date_o,
  output logic [15:0] modified_time_o,
  output logic        name_store_overflowed_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SRD   = 3'd1;
  localparam logic [2:0] S_SPR   = 3'd2;
  localparam logic [2:0] S_EFILL = 3'd3;
  localparam logic [2:0] S_EAPP  = 3'd4;
  localparam logic [2:0] S_EOUT  = 3'd5;

  // control state
  logic [2:0]      state_q, state_d;
  logic [7:0]      mask_q;
  logic [CntW-1:0] count_q, count_d;
  logic            ovf_q, ovf_d;
  logic            ended_q, ended_d;
  logic [AddrW-1:0] idx_q, idx_d;
  logic [AddrW-1:0] last_idx_q, last_idx_d;
  logic            use_short_q, use_short_d;
  logic [8:0]      pos_q, pos_d;
  logic [8:0]      len_q, len_d;
  logic            stop_q, stop_d;
  logic [4:0]      acc_n_q, acc_n_d;
  logic [8:0]      epos_q, epos_d;
  logic            out_valid_q, out_valid_d;

  // entry payload held for the duration of the entry
  byte_t           acc_q [AccBytes];
  byte_t           acc_d [AccBytes];
  byte_t           short_q [PartChars];
  byte_t           short_d [PartChars];
  logic [3:0]      short_len_q, short_len_d;
  logic [7:0]      attr_q;
  logic            meta_ovf_q;
  logic [31:0]     size_q;
  logic [15:0]     clus_q, cdate_q, ctime_q, mdate_q, mtime_q;

  // output register
  logic            o_kind_q, o_last_q, o_dir_q, o_ovf_q;
  logic [63:0]     o_chunk_q;
  logic [3:0]      o_len_q;
  logic [31:0]     o_size_q;
  logic [15:0]     o_clus_q, o_cdate_q, o_ctime_q, o_mdate_q, o_mtime_q;

  logic            accept, out_free, load_end, load_chunk;
  logic [255:0]    ent;
  byte_t           b [32];

  always_comb begin
    ent = {entry_bytes_24_31_i, entry_bytes_16_23_i, entry_bytes_8_15_i, entry_bytes_0_7_i};
    for (int i = 0; i < 32; i++) begin
      b[i] = ent[8*i +: 8];
    end
  end

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  // long-name part compaction: each group stops at its first 0x0000 or 0xffff
  logic [PartWidth-1:0] lfn_word;
  always_comb begin
    int unsigned dst;
    logic alive;
    logic [15:0] c;
    lfn_word = '0;
    dst   = 0;
    alive = 1'b1;
    for (int k = 0; k < PartChars; k++) begin
      if (k == 5 || k == 11) begin
        alive = 1'b1;
      end
      c = {b[LfnOffset[k] + 5'd1], b[LfnOffset[k]]};
      if (c == 16'h0000 || c == 16'hFFFF) begin
        alive = 1'b0;
      end
      if (alive) begin
        lfn_word[8*dst +: 8] = c[7:0];
        dst = dst + 1;
      end
    end
    lfn_word[PartWidth-1 -: 4] = 4'(dst);
  end

  // 8.3 short name with the dot inserted
  logic [3:0] n1;
  logic [1:0] n2;
  logic       has_ext;
  byte_t      sn [PartChars];
  logic [3:0] sn_len;
  always_comb begin
    int k;
    n1 = 4'd8;
    for (int i = 7; i >= 0; i--) begin
      if (b[i] == ChSpace) n1 = 4'(i);
    end
    has_ext = (b[8] != ChSpace);
    n2 = (b[9] == ChSpace) ? 2'd1 : ((b[10] == ChSpace) ? 2'd2 : 2'd3);
    for (int j = 0; j < PartChars; j++) begin
      k = j - int'(n1) - 1;
      sn[j] = '0;
      if (j < int'(n1)) begin
        sn[j] = b[j];
      end else if (has_ext && j == int'(n1)) begin
        sn[j] = ChDot;
      end else if (has_ext && k >= 0 && k < int'(n2)) begin
        sn[j] = b[8 + k];
      end
    end
    sn_len = n1 + (has_ext ? 4'(n2) + 4'd1 : 4'd0);
  end

  // part ram
  logic                 ram_we;
  logic [AddrW-1:0]     ram_waddr;
  logic [PartWidth-1:0] ram_rdata;

  fdes_ram #(
    .Width (PartWidth),
    .Depth (LONG_NAME_PARTS)
  ) u_part_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (lfn_word),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  // current part, from the ram or the latched short name
  byte_t      src_b [PartChars];
  logic [3:0] src_len;
  always_comb begin
    for (int j = 0; j < PartChars; j++) begin
      src_b[j] = use_short_q ? short_q[j] : ram_rdata[8*j +: 8];
    end
    src_len = use_short_q ? short_len_q : ram_rdata[PartWidth-1 -: 4];
  end

  // zero stop and last non-space within the part
  logic       zf;
  logic [3:0] lns;
  always_comb begin
    zf  = 1'b0;
    lns = '0;
    for (int j = 0; j < PartChars; j++) begin
      if (!zf && 4'(j) < src_len) begin
        if (src_b[j] == ChEnd) begin
          zf = 1'b1;
        end else if (src_b[j] != ChSpace) begin
          lns = 4'(j + 1);
        end
      end
    end
  end

  logic [8:0] remain;
  logic       fits;
  logic [3:0] n_out;
  logic       last_out;
  logic [63:0] chunk;
  assign remain   = len_q - epos_q;
  assign fits     = (acc_n_q >= 5'd8) || ({4'd0, acc_n_q} >= remain);
  assign last_out = (remain <= 9'd8);
  assign n_out    = last_out ? remain[3:0] : 4'd8;
  always_comb begin
    chunk = '0;
    for (int j = 0; j < 8; j++) begin
      if (4'(j) < n_out) chunk[8*j +: 8] = acc_q[j];
    end
  end

  always_comb begin
    logic [CntW-1:0] cnt;
    logic            ov, en;
    state_d     = state_q;
    count_d     = count_q;
    ovf_d       = ovf_q;
    ended_d     = ended_q;
    idx_d       = idx_q;
    last_idx_d  = last_idx_q;
    use_short_d = use_short_q;
    pos_d       = pos_q;
    len_d       = len_q;
    stop_d      = stop_q;
    acc_n_d     = acc_n_q;
    epos_d      = epos_q;
    acc_d       = acc_q;
    short_d     = short_q;
    short_len_d = short_len_q;
    ram_we      = 1'b0;
    ram_waddr   = count_q[AddrW-1:0];
    load_end    = 1'b0;
    load_chunk  = 1'b0;
    cnt = first_of_directory_i ? '0 : count_q;
    ov  = first_of_directory_i ? 1'b0 : ovf_q;
    en  = first_of_directory_i ? 1'b0 : ended_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          count_d = cnt;
          ovf_d   = ov;
          ended_d = en;
          ram_waddr = cnt[AddrW-1:0];
          if (!en) begin
            if (b[0] == ChEnd) begin
              ended_d  = 1'b1;
              load_end = 1'b1;
            end else if (b[0] == ChDeleted) begin
              // deleted entry, nothing to do
            end else if (b[11] == AttrLfn) begin
              if (cnt == CntW'(LONG_NAME_PARTS)) begin
                ovf_d = 1'b1;
              end else begin
                ram_we  = 1'b1;
                count_d = cnt + 1'b1;
              end
            end else begin
              use_short_d = (cnt == '0);
              last_idx_d  = (cnt == '0) ? '0 : AddrW'(cnt - 1'b1);
              idx_d       = (cnt == '0) ? '0 : AddrW'(cnt - 1'b1);
              for (int j = 0; j < PartChars; j++) short_d[j] = sn[j];
              short_len_d = sn_len;
              count_d = '0;
              ovf_d   = 1'b0;
              pos_d   = '0;
              len_d   = '0;
              stop_d  = 1'b0;
              state_d = S_SRD;
            end
          end
        end
      end
      S_SRD: state_d = S_SPR;
      S_SPR: begin
        if (!stop_q) begin
          if (lns != '0) len_d = pos_q + 9'(lns);
          pos_d = pos_q + 9'(src_len);
          if (zf) stop_d = 1'b1;
        end
        if (idx_q == '0 || zf || stop_q) begin
          if (len_d == '0 || (attr_q & mask_q) != '0) begin
            state_d = S_IDLE;
          end else begin
            idx_d   = last_idx_q;
            acc_n_d = '0;
            epos_d  = '0;
            state_d = S_EFILL;
          end
        end else begin
          idx_d   = idx_q - 1'b1;
          state_d = S_SRD;
        end
      end
      S_EFILL: state_d = fits ? S_EOUT : S_EAPP;
      S_EAPP: begin
        for (int j = 0; j < PartChars; j++) begin
          if (4'(j) < src_len) acc_d[5'(acc_n_q + 5'(j))] = src_b[j];
        end
        acc_n_d = acc_n_q + 5'(src_len);
        idx_d   = idx_q - 1'b1;
        state_d = S_EFILL;
      end
      S_EOUT: begin
        if (out_free) begin
          load_chunk = 1'b1;
          if (last_out) begin
            state_d = S_IDLE;
          end else begin
            for (int j = 0; j < AccBytes - 8; j++) acc_d[j] = acc_q[j + 8];
            acc_n_d = acc_n_q - 5'd8;
            epos_d  = epos_q + 9'd8;
            state_d = S_EFILL;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_end || load_chunk) out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mask_q      <= MaskReset;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      ended_q     <= 1'b0;
      idx_q       <= '0;
      last_idx_q  <= '0;
      use_short_q <= 1'b0;
      pos_q       <= '0;
      len_q       <= '0;
      stop_q      <= 1'b0;
      acc_n_q     <= '0;
      epos_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) mask_q <= cfg_wdata_i;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      ended_q     <= ended_d;
      idx_q       <= idx_d;
      last_idx_q  <= last_idx_d;
      use_short_q <= use_short_d;
      pos_q       <= pos_d;
      len_q       <= len_d;
      stop_q      <= stop_d;
      acc_n_q     <= acc_n_d;
      epos_q      <= epos_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    acc_q       <= acc_d;
    short_q     <= short_d;
    short_len_q <= short_len_d;
    if (accept) begin
      attr_q     <= b[11];
      meta_ovf_q <= first_of_directory_i ? 1'b0 : ovf_q;
      size_q     <= {b[31], b[30], b[29], b[28]};
      clus_q     <= {b[27], b[26]};
      cdate_q    <= {b[17], b[16]};
      ctime_q    <= {b[15], b[14]};
      mdate_q    <= {b[25], b[24]};
      mtime_q    <= {b[23], b[22]};
    end
    if (load_end) begin
      o_kind_q  <= 1'b1;
      o_chunk_q <= '0;
      o_len_q   <= '0;
      o_last_q  <= 1'b1;
      o_dir_q   <= 1'b0;
      o_size_q  <= '0;
      o_clus_q  <= '0;
      o_cdate_q <= '0;
      o_ctime_q <= '0;
      o_mdate_q <= '0;
      o_mtime_q <= '0;
      o_ovf_q   <= 1'b0;
    end else if (load_chunk) begin
      o_kind_q  <= 1'b0;
      o_chunk_q <= chunk;
      o_len_q   <= n_out;
      o_last_q  <= last_out;
      o_dir_q   <= (attr_q & AttrDir) != '0;
      o_size_q  <= size_q;
      o_clus_q  <= clus_q;
      o_cdate_q <= cdate_q;
      o_ctime_q <= ctime_q;
      o_mdate_q <= mdate_q;
      o_mtime_q <= mtime_q;
      o_ovf_q   <= meta_ovf_q;
    end
  end

  assign out_valid_o             = out_valid_q;
  assign record_kind_o           = o_kind_q;
  assign name_chunk_o            = o_chunk_q;
  assign chunk_length_o          = o_len_q;
  assign last_chunk_o            = o_last_q;
  assign is_directory_o          = o_dir_q;
  assign file_size_o             = o_size_q;
  assign first_cluster_o         = o_clus_q;
  assign created_date_o          = o_cdate_q;
  assign created_time_o          = o_ctime_q;
  assign modified_date_o         = o_mdate_q;
  assign modified_time_o         = o_mtime_q;
  assign name_store_overflowed_o = o_ovf_q;

  // part count never exceeds the store
  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(LONG_NAME_PARTS))
    else $error("part count beyond store");

  // gather buffer never overruns
  a_acc_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_n_q <= 5'(AccBytes - 1))
    else $error("gather buffer overrun");

  // a chunk never goes past the scanned name length
  a_chunk_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_chunk |-> (epos_q + 9'(n_out) <= len_q) && (n_out != '0))
    else $error("chunk beyond name length");

  // a loaded result is presented on the next cycle
  a_load_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_end || load_chunk) |=> out_valid_q)
    else $error("loaded result not presented");

endmodule

@@ dv/fdes_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdes_checker
// watches the entry and record channels, predicts the records of each entry
// and compares every record beat field by field, oldest first
// ----------------------------------------------------------------------------
module fdes_checker
  import fdes_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        first_of_directory_i,
  input  logic [63:0] entry_bytes_0_7_i,
  input  logic [63:0] entry_bytes_8_15_i,
  input  logic [63:0] entry_bytes_16_23_i,
  input  logic [63:0] entry_bytes_24_31_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic        record_kind_i,
  input  logic [63:0] name_chunk_i,
  input  logic [3:0]  chunk_length_i,
  input  logic        last_chunk_i,
  input  logic        is_directory_i,
  input  logic [31:0] file_size_i,
  input  logic [15:0] first_cluster_i,
  input  logic [15:0] created_date_i,
  input  logic [15:0] created_time_i,
  input  logic [15:0] modified_date_i,
  input  logic [15:0] modified_time_i,
  input  logic        name_store_overflowed_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  typedef struct packed {
    logic        kind;
    logic [63:0] chunk;
    logic [3:0]  len;
    logic        last;
    logic        dir;
    logic [31:0] size;
    logic [15:0] clus;
    logic [15:0] cdate;
    logic [15:0] ctime;
    logic [15:0] mdate;
    logic [15:0] mtime;
    logic        ovf;
  } record_t;

  record_t     record_q [$];
  byte_t       part_chars [LongNameParts][PartChars];
  int unsigned part_len [LongNameParts];
  int unsigned part_cnt;
  logic        ovf_seen;
  logic        dir_ended;
  logic [7:0]  skip_mask;

  assign pending_o = record_q.size();

  task automatic predict_entry(input logic fod, input logic [255:0] raw);
    byte_t       b [32];
    byte_t       name [260];
    int unsigned len, n, k, pos;
    logic [15:0] c;
    logic [7:0]  attr;
    logic        ovf;
    record_t     r;
    len = 0;
    for (int i = 0; i < 32; i++) b[i] = raw[8*i +: 8];
    if (fod) begin
      part_cnt = 0; ovf_seen = 1'b0; dir_ended = 1'b0;
    end
    if (dir_ended) return;
    if (b[0] == ChEnd) begin
      dir_ended = 1'b1;
      r = '0; r.kind = 1'b1; r.last = 1'b1;
      record_q.push_back(r);
      return;
    end
    if (b[0] == ChDeleted) return;
    attr = b[11];
    if (attr == AttrLfn) begin
      if (part_cnt >= LongNameParts) begin
        ovf_seen = 1'b1;
        return;
      end
      n = 0; k = 0;
      while (k < PartChars) begin
        c = {b[LfnOffset[k] + 1], b[LfnOffset[k]]};
        if (c == 16'h0000 || c == 16'hFFFF) begin
          // a terminator ends its character group
          k = (k < 5) ? 5 : (k < 11) ? 11 : 13;
        end else begin
          part_chars[part_cnt][n] = c[7:0];
          n++; k++;
        end
      end
      part_len[part_cnt] = n;
      part_cnt++;
      return;
    end
    if (part_cnt > 0) begin
      for (int p = part_cnt - 1; p >= 0; p--)
        for (int j = 0; j < part_len[p]; j++)
          if (len < 260) begin name[len] = part_chars[p][j]; len++; end
    end else begin
      for (int i = 0; i < 8 && b[i] != ChSpace; i++) begin name[len] = b[i]; len++; end
      if (b[8] != ChSpace) begin
        name[len] = ChDot; len++;
        for (int i = 8; i < 11 && b[i] != ChSpace; i++) begin name[len] = b[i]; len++; end
      end
    end
    ovf = ovf_seen;
    part_cnt = 0;
    ovf_seen = 1'b0;
    for (int i = 0; i < len; i++)
      if (name[i] == 8'h00) begin len = i; break; end
    while (len > 0 && name[len-1] == ChSpace) len--;
    if (len == 0 || (attr & skip_mask) != 0) return;
    pos = 0;
    while (pos < len) begin
      n = (len - pos > 8) ? 8 : len - pos;
      r = '0;
      for (int j = 0; j < n; j++) r.chunk[8*j +: 8] = name[pos + j];
      pos += n;
      r.len   = 4'(n);
      r.last  = (pos == len);
      r.dir   = attr[4];
      r.size  = {b[31], b[30], b[29], b[28]};
      r.clus  = {b[27], b[26]};
      r.cdate = {b[17], b[16]};
      r.ctime = {b[15], b[14]};
      r.mdate = {b[25], b[24]};
      r.mtime = {b[23], b[22]};
      r.ovf   = ovf;
      record_q.push_back(r);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    record_t act, exp_r;
    if (!rst_ni) begin
      part_cnt     = 0;
      ovf_seen     = 1'b0;
      dir_ended    = 1'b0;
      skip_mask    = MaskReset;
      fail_count_o = 0;
    end else begin
      if (cfg_we_i) skip_mask = cfg_wdata_i;
      if (out_valid_i && !out_stall_i) begin
        act = '{record_kind_i, name_chunk_i, chunk_length_i, last_chunk_i, is_directory_i,
                file_size_i, first_cluster_i, created_date_i, created_time_i,
                modified_date_i, modified_time_i, name_store_overflowed_i};
        if (record_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10) $display("unexpected record beat %h", act);
        end else begin
          exp_r = record_q.pop_front();
          if (act !== exp_r) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("record mismatch\n  exp %h\n  got %h", exp_r, act);
          end
        end
      end
      // entries are predicted after the compare: a record never leaves in its own cycle
      if (in_valid_i && !in_stall_i)
        predict_entry(first_of_directory_i, {entry_bytes_24_31_i, entry_bytes_16_23_i,
                                             entry_bytes_8_15_i, entry_bytes_0_7_i});
    end
  end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives directory entries (short names, long-name runs, deleted, end marks)
// through the scanner under random idling; the checker judges every record
// ----------------------------------------------------------------------------
module testbench
  import fdes_pkg::*;
();

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [7:0]  cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        first_of_directory_i = 1'b0;
  logic [63:0] entry_bytes_0_7_i = '0;
  logic [63:0] entry_bytes_8_15_i = '0;
  logic [63:0] entry_bytes_16_23_i = '0;
  logic [63:0] entry_bytes_24_31_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        record_kind_o;
  logic [63:0] name_chunk_o;
  logic [3:0]  chunk_length_o;
  logic        last_chunk_o;
  logic        is_directory_o;
  logic [31:0] file_size_o;
  logic [15:0] first_cluster_o;
  logic [15:0] created_date_o;
  logic [15:0] created_time_o;
  logic [15:0] modified_date_o;
  logic [15:0] modified_time_o;
  logic        name_store_overflowed_o;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_count = 0;
  logic        calm_window = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  fat_directory_entry_scanner_core u_top (.*);

  fdes_checker u_check (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i,
    .in_stall_i(in_stall_o), .first_of_directory_i,
    .entry_bytes_0_7_i, .entry_bytes_8_15_i, .entry_bytes_16_23_i,
    .entry_bytes_24_31_i, .out_valid_i(out_valid_o), .out_stall_i,
    .record_kind_i(record_kind_o), .name_chunk_i(name_chunk_o),
    .chunk_length_i(chunk_length_o), .last_chunk_i(last_chunk_o),
    .is_directory_i(is_directory_o), .file_size_i(file_size_o),
    .first_cluster_i(first_cluster_o), .created_date_i(created_date_o),
    .created_time_i(created_time_o), .modified_date_i(modified_date_o),
    .modified_time_i(modified_time_o),
    .name_store_overflowed_i(name_store_overflowed_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // run limit, far above the slowest legal run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // sink side: random stall beats, none while the calm window is open
  always @(posedge clk_i)
    out_stall_i <= !calm_window && ($urandom_range(99) < 8);

  // one entry beat; the sender may idle a random gap first
  task automatic send_entry(input logic fod, input logic [255:0] raw);
    if (!calm_window && $urandom_range(99) < 8) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i           <= 1'b1;
    first_of_directory_i <= fod;
    {entry_bytes_24_31_i, entry_bytes_16_23_i, entry_bytes_8_15_i, entry_bytes_0_7_i} <= raw;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // random metadata, attribute and name bytes overlaid
  function automatic logic [255:0] rand_entry();
    logic [255:0] e;
    for (int i = 0; i < 8; i++) e[32*i +: 32] = $urandom;
    return e;
  endfunction

  function automatic logic [255:0] short_entry(input logic [7:0] attr);
    logic [255:0] e;
    e = rand_entry();
    for (int i = 0; i < 11; i++)
      case ($urandom_range(5))
        0:       e[8*i +: 8] = ChSpace;
        1:       e[8*i +: 8] = 8'($urandom);
        default: e[8*i +: 8] = 8'($urandom_range(8'h41, 8'h5a));
      endcase
    if (e[7:0] == ChEnd || e[7:0] == ChDeleted) e[7:0] = 8'h41;
    e[95:88] = attr;
    return e;
  endfunction

  // long-name part with random terminators in its character groups
  function automatic logic [255:0] lfn_entry();
    logic [255:0] e;
    e = rand_entry();
    e[7:0] = 8'($urandom_range(1, 8'h7f));
    for (int k = 0; k < PartChars; k++)
      case ($urandom_range(9))
        0:       e[8*LfnOffset[k] +: 16] = 16'h0000;
        1:       e[8*LfnOffset[k] +: 16] = 16'hFFFF;
        2:       e[8*LfnOffset[k] +: 16] = 16'($urandom);
        3:       e[8*LfnOffset[k] +: 16] = {8'($urandom), ChSpace};
        default: e[8*LfnOffset[k] +: 16] = {8'h00, 8'($urandom_range(8'h61, 8'h7a))};
      endcase
    e[95:88] = AttrLfn;
    return e;
  endfunction

  function automatic logic [7:0] rand_attr();
    case ($urandom_range(3))
      0:       return 8'($urandom);
      1:       return AttrDir;
      default: return 8'h20;
    endcase
  endfunction

  // wait for every record, then let a late name scan drain
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_mask(input logic [7:0] m);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    logic [255:0] e;
    int unsigned nparts;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: all-ones and all-zero fields, dot-less name, deleted long-name part
    e = '1; e[95:88] = 8'h20; send_entry(1'b1, e);
    e = short_entry(8'h00); e[71:64] = ChSpace; send_entry(1'b0, e);
    e = '1; e[7:0] = 8'h05; e[95:88] = 8'h00; send_entry(1'b0, e);
    e = '0; e[7:0] = ChDeleted; e[95:88] = AttrLfn; send_entry(1'b0, e);
    e = 256'({11{ChSpace}}); e[7:0] = 8'h41; send_entry(1'b0, e);
    // all-space name is empty; zero byte inside a short name cuts it
    e = 256'({11{ChSpace}}); e[7:0] = ChSpace; send_entry(1'b0, e);
    e = short_entry(8'h20); e[23:16] = 8'h00; send_entry(1'b0, e);
    e = short_entry(8'h02); send_entry(1'b0, e);
    // long name of 20 full parts plus two dropped: longest output, overflow
    for (int p = 0; p < 22; p++) begin
      e = '1; e[7:0] = 8'h41;
      for (int k = 0; k < PartChars; k++) e[8*LfnOffset[k] +: 16] = 16'h0061 + 16'(k);
      e[95:88] = AttrLfn; send_entry(1'b0, e);
    end
    send_entry(1'b0, short_entry(AttrDir));
    // end of directory, ignored entry, then a fresh directory
    e = rand_entry(); e[7:0] = ChEnd; send_entry(1'b0, e);
    send_entry(1'b0, short_entry(8'h20));
    send_entry(1'b1, short_entry(8'h20));
    drain();

    // random phases across mask settings, extremes among them
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_mask(8'h00);
        1: write_mask(8'hFF);
        2: write_mask(8'h10);
        3: write_mask(8'($urandom));
        default: write_mask(MaskReset);
      endcase
      calm_window = (ph == 2);
      for (int it = 0; it < 16; it++) begin
        case ($urandom_range(9))
          0, 1, 2, 3: begin
            nparts = ($urandom_range(9) == 0) ? $urandom_range(18, 22) : $urandom_range(1, 3);
            for (int p = 0; p < nparts; p++) send_entry(1'b0, lfn_entry());
            send_entry(1'b0, short_entry(rand_attr()));
          end
          4, 5, 6: send_entry(1'b0, short_entry(rand_attr()));
          7: begin
            e = rand_entry(); e[7:0] = ChDeleted; send_entry(1'b0, e);
          end
          8: begin
            e = rand_entry(); e[7:0] = ChEnd; send_entry(1'b0, e);
          end
          default: send_entry(1'b1, rand_entry());
        endcase
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ fat_directory_entry_scanner_core.f @@
rtl/core/fdes_pkg.sv
rtl/core/fdes_ram.sv
rtl/core/fat_directory_entry_scanner_core.sv
dv/fdes_checker.sv
dv/testbench.sv
